// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL. The checks compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define AST_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define AST_HOLDS(lbl, prop, msg)
`define AST_NEVER(lbl, expr, msg)
`endif
`endif

// ----- design/ovn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// ovn2d_pkg
// Types and constants shared by the octave value noise block.
// ----------------------------------------------------------------------------
package ovn2d_pkg;

    localparam int MAP_SIZE = 256;
    localparam int MAP_BITS = $clog2(MAP_SIZE);
    localparam int ADDR_BITS = 2 * MAP_BITS;

    localparam logic [2:0]  MAX_OCTAVES   = 3'd6;
    localparam logic [2:0]  RST_OCTAVES   = 3'd6;
    localparam logic [15:0] RST_BIAS      = 16'd8192;
    localparam logic [31:0] WEIGHT_ONE    = 32'h0001_0000;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    localparam logic CFG_OCTAVES = 1'b0;
    localparam logic CFG_BIAS    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [15:0] seed_value;
    } t_item;

    typedef struct packed {
        logic [15:0] noise_value;
        logic [7:0]  out_x;
        logic [7:0]  out_y;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MULT,
        S_ACCUM,
        S_VMUL,
        S_SUM,
        S_WDIV,
        S_WWAIT,
        S_FDIV,
        S_FWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       wr;
        logic       load;
        logic       rd;
        logic       mul;
        logic       acc_add;
        logic       acc_clr;
        logic       vmul;
        logic       num_add;
        logic       wdiv_start;
        logic       fdiv_start;
        logic       w_load;
        logic       res_load;
        logic       res_clr;
        logic [2:0] octave;
        logic [1:0] corner;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_stat;

endpackage

// ----- design/ovn2d_dpath.sv -----
// ----------------------------------------------------------------------------
// ovn2d_dpath
// Seed memory, bilinear blend, weighted sums and a shared shift-subtract divider.
// ----------------------------------------------------------------------------
module ovn2d_dpath
    import ovn2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  t_item       i_item,
    input  logic [15:0] i_scaling_bias,
    output t_result     o_result
);

    logic [15:0] r_mem [0:(1 << ADDR_BITS) - 1];

    logic [MAP_BITS-1:0] r_x, r_y;
    logic [15:0] r_rdata;
    logic [16:0] r_cw;
    logic [32:0] r_prod;
    logic [32:0] r_acc;
    logic [47:0] r_prod2;
    logic [50:0] r_num;
    logic [34:0] r_den;
    logic [31:0] r_w;
    logic [34:0] r_rem;
    logic [34:0] r_dvs;
    logic [31:0] r_dsh;
    logic [31:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_ovf;
    logic [15:0] r_res;

    logic [3:0]  shift;
    logic [8:0]  period, msk, dx, dy, wx, wy;
    logic [7:0]  x1, y1, x2, y2, xs, ys;
    logic [17:0] cw_full;
    logic [4:0]  shamt;
    logic [15:0] oct_val;
    logic [35:0] trial;
    logic        qbit;

    always_comb begin
        shift   = 4'(MAP_BITS) - {1'b0, i_cmd.octave};
        period  = 9'(1) << shift;
        msk     = period - 9'd1;
        dx      = {1'b0, r_x} & msk;
        dy      = {1'b0, r_y} & msk;
        x1      = r_x & ~msk[7:0];
        y1      = r_y & ~msk[7:0];
        // When the period is the whole map the far corner wraps onto the near one.
        x2      = x1 + period[7:0];
        y2      = y1 + period[7:0];
        xs      = i_cmd.corner[0] ? x2 : x1;
        ys      = i_cmd.corner[1] ? y2 : y1;
        wx      = i_cmd.corner[0] ? dx : period - dx;
        wy      = i_cmd.corner[1] ? dy : period - dy;
        cw_full = wx * wy;
        shamt   = {shift, 1'b0};
        oct_val = 16'(r_acc >> shamt);
        trial   = {r_rem, r_dsh[31]};
        qbit    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[{i_item.cell_y, i_item.cell_x}] <= i_item.seed_value;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[{ys, xs}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_item.cell_x;
            r_y   <= i_item.cell_y;
            r_num <= '0;
            r_den <= '0;
            r_w   <= WEIGHT_ONE;
        end
        if (i_cmd.rd) begin
            r_cw <= 17'(cw_full);
        end
        if (i_cmd.mul) begin
            r_prod <= 33'(r_rdata * r_cw);
        end
        if (i_cmd.load || i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.vmul) begin
            r_prod2 <= oct_val * r_w;
        end
        if (i_cmd.num_add) begin
            r_num <= r_num + 51'(r_prod2);
            r_den <= r_den + 35'(r_w);
        end
        if (i_cmd.w_load) begin
            r_w <= r_ovf ? '1 : r_q;
        end
        if (i_cmd.res_clr) begin
            r_res <= '0;
        end else if (i_cmd.res_load) begin
            r_res <= r_q[15:0];
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.wdiv_start) begin
            r_cnt <= 6'd32;
        end else if (i_cmd.fdiv_start) begin
            r_cnt <= 6'd16;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wdiv_start) begin
            // A quotient of more than 32 bits (or a zero divisor) saturates.
            r_ovf <= {4'd0, r_w[31:20]} >= i_scaling_bias;
            r_rem <= 35'(r_w[31:20]);
            r_dvs <= 35'(i_scaling_bias);
            r_dsh <= {r_w[19:0], 12'd0};
            r_q   <= '0;
        end else if (i_cmd.fdiv_start) begin
            r_ovf <= 1'b0;
            r_rem <= r_num[50:16];
            r_dvs <= r_den;
            r_dsh <= {r_num[15:0], 16'd0};
            r_q   <= '0;
        end else if (r_cnt != 6'd0) begin
            r_rem <= qbit ? 35'(trial - {1'b0, r_dvs}) : trial[34:0];
            r_dsh <= {r_dsh[30:0], 1'b0};
            r_q   <= {r_q[30:0], qbit};
        end
    end

    assign o_stat.div_done     = (r_cnt == 6'd0);
    assign o_result.noise_value = r_res;
    assign o_result.out_x       = r_x;
    assign o_result.out_y       = r_y;

endmodule

// ----- design/ovn2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// ovn2d_ctrl
// Sequencer that walks octaves and corners and drives the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ovn2d_ctrl
    import ovn2d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_action,
    input  logic [2:0] i_octave_count,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    t_state     r_state, n_state;
    logic [2:0] r_oct, n_oct;
    logic [2:0] r_noct, n_noct;
    logic [1:0] r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oct    <= '0;
            r_noct   <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_oct    <= n_oct;
            r_noct   <= n_noct;
            r_corner <= n_corner;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_oct    = r_oct;
        n_noct   = r_noct;
        n_corner = r_corner;
        o_cmd        = '0;
        o_cmd.octave = r_oct;
        o_cmd.corner = r_corner;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_oct      = '0;
                        n_corner   = '0;
                        n_noct     = (i_octave_count > MAX_OCTAVES) ? 3'd0 : i_octave_count;
                        if (i_octave_count == 3'd0 || i_octave_count > MAX_OCTAVES) begin
                            o_cmd.res_clr = 1'b1;
                            n_state       = S_OUT;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MULT;
            end
            S_MULT: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.acc_add = 1'b1;
                n_corner      = r_corner + 2'd1;
                n_state       = (r_corner == 2'd3) ? S_VMUL : S_READ;
            end
            S_VMUL: begin
                o_cmd.vmul = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.num_add = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = (r_oct == r_noct - 3'd1) ? S_FDIV : S_WDIV;
            end
            S_WDIV: begin
                o_cmd.wdiv_start = 1'b1;
                n_state          = S_WWAIT;
            end
            S_WWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.w_load = 1'b1;
                    n_oct        = r_oct + 3'd1;
                    n_corner     = '0;
                    n_state      = S_READ;
                end
            end
            S_FDIV: begin
                o_cmd.fdiv_start = 1'b1;
                n_state          = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    `AST_HOLDS(a_idle_after_result, o_valid |=> !o_busy, "result not followed by idle")
    `AST_HOLDS(a_compute_busy, (i_start && !o_busy && i_action == ACT_COMPUTE) |=> o_busy, "compute not started")
    `AST_HOLDS(a_write_single, (i_start && !o_busy && i_action == ACT_WRITE) |=> !o_busy, "write took more than one cycle")
    `AST_NEVER(a_octave_range, (r_state == S_READ) && (r_oct >= r_noct), "octave index past count")

endmodule

// ----- design/octave_value_noise_2d.sv -----
// A write transfer completes in the cycle it is accepted. A compute transfer walks the
// read, multiply, accumulate, sum and divide states per octave; at zero it goes to output.
// Throughput: one item at a time; the next may start the cycle after the strobe.
// The per-octave weight division (32 steps) and final divide (16 steps) dominate.
// Reset (synchronous, active low) sets 6 octaves and bias 8192; the seed map is not cleared.
// ----------------------------------------------------------------------------
// octave_value_noise_2d
// Multi-octave bilinear value noise over a wrapping 256 x 256 seed map.
// ----------------------------------------------------------------------------
module octave_value_noise_2d
    import ovn2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_item       i_item,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers. Writes are always taken; the user must make them only while
    // the block is idle, so a running computation never sees them change. The block does not enforce this.
    logic [2:0]  r_octave_count;
    logic [15:0] r_scaling_bias;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= RST_OCTAVES;
            r_scaling_bias <= RST_BIAS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OCTAVES: r_octave_count <= i_cfg_data[2:0];
                CFG_BIAS:    r_scaling_bias <= i_cfg_data;
                default:     r_octave_count <= r_octave_count;
            endcase
        end
    end

    // The sequencer walks each octave's four corners, then accumulates the weighted
    // octave value, then divides the weight for the next octave or, after the last, normalizes.
    ovn2d_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_action       (i_item.action),
        .i_octave_count (r_octave_count),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd),
        .o_busy         (o_busy),
        .o_valid        (o_valid)
    );

    // The datapath holds the seed memory, one multiplier per stage and the
    // divider that is shared by the weight update and the final normalization.
    ovn2d_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_item         (i_item),
        .i_scaling_bias (r_scaling_bias),
        .o_result       (o_result)
    );

endmodule

// ----- test/octave_value_noise_2d_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// octave_value_noise_2d_tb
// Self-checking bench for the octave value noise block. Seed writes and noise
// lookups are queued by a stimulus process, and a clocked driver transfers
// them. A clocked monitor predicts each accepted item and checks every strobed
// result, in order, against the predicted noise value and cell echo.
// ----------------------------------------------------------------------------
module octave_value_noise_2d_tb;
    import ovn2d_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_item       i_item;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    octave_value_noise_2d u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Items waiting to be transferred, and noise results still owed by the block.
    t_item   pending_items[$];
    t_result noise_due[$];

    // Predictor state: a copy of the seed map and of both registers.
    logic [15:0] seed_grid [0:MAP_SIZE*MAP_SIZE-1];
    logic [2:0]  pred_octaves;
    logic [15:0] pred_bias;

    // Stimulus side bookkeeping: which seed entries have a write queued, so that
    // no lookup ever touches a corner that has not been written.
    bit          seeded [0:MAP_SIZE*MAP_SIZE-1];

    int          idle_pct;
    logic        took;
    int          errors;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Bilinear blend of one octave at cell (x, y), sample period MAP_SIZE >> oct.
    function automatic longint unsigned octave_blend(int x, int y, int oct);
        int p;
        int x1, y1, x2, y2, dx, dy;
        longint unsigned acc;
        longint unsigned v;
        p  = MAP_SIZE >> oct;
        x1 = (x / p) * p;
        y1 = (y / p) * p;
        x2 = (x1 + p) % MAP_SIZE;
        y2 = (y1 + p) % MAP_SIZE;
        dx = x - x1;
        dy = y - y1;
        acc = longint'((p - dx) * (p - dy)) * seed_grid[y1*MAP_SIZE + x1]
            + longint'(dx * (p - dy)) * seed_grid[y1*MAP_SIZE + x2]
            + longint'((p - dx) * dy) * seed_grid[y2*MAP_SIZE + x1]
            + longint'(dx * dy) * seed_grid[y2*MAP_SIZE + x2];
        v = acc / longint'(p * p);
        return (v > 65535) ? 65535 : v;
    endfunction

    // Weighted octave sum normalized by the weight total. A count of seven
    // behaves like zero octaves, and zero octaves give zero instead of 0/0.
    function automatic logic [15:0] octave_noise(int x, int y);
        longint unsigned num, den, w, nw, res;
        int n;
        num = 0;
        den = 0;
        w   = 65536;
        n   = (pred_octaves > MAX_OCTAVES) ? 0 : int'(pred_octaves);
        for (int o = 0; o < n; o++) begin
            num += octave_blend(x, y, o) * w;
            den += w;
            if (pred_bias == 0) begin
                // A zero divisor counts as the smallest step: the weight saturates.
                w = 64'hFFFF_FFFF;
            end else begin
                nw = (w * 4096) / pred_bias;
                w  = (nw > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nw;
            end
        end
        res = 0;
        if (den != 0) begin
            res = num / den;
            if (res > 65535) res = 65535;
        end
        return res[15:0];
    endfunction

    // Update the seed copy for a write, or queue the expected noise for a lookup.
    task automatic predict_item(t_item it);
        t_result r;
        if (it.action == ACT_WRITE) begin
            seed_grid[int'(it.cell_y)*MAP_SIZE + int'(it.cell_x)] = it.seed_value;
        end else begin
            r.noise_value = octave_noise(int'(it.cell_x), int'(it.cell_y));
            r.out_x = it.cell_x;
            r.out_y = it.cell_y;
            noise_due.push_back(r);
        end
    endtask

    // Driver: a new item goes out at the falling edge once the previous one
    // has been transferred. start stays high from one item to the next unless a
    // random idle draw drops it; while an item waits to be taken, start is left alone.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || took) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_start <= 1'b1;
                i_item  <= pending_items.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: results are checked before the item accepted at the same edge
    // is predicted, since a strobed result always belongs to an earlier item.
    always @(posedge i_clk) begin
        t_result want;
        took <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (noise_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h/%0d/%0d",
                             $time, o_result.noise_value, o_result.out_x, o_result.out_y);
                    errors++;
                end else begin
                    want = noise_due.pop_front();
                    if (o_result.noise_value !== want.noise_value) begin
                        $display("%0t: noise_value mismatch: expected %h, actual %h",
                                 $time, want.noise_value, o_result.noise_value);
                        errors++;
                    end
                    if (o_result.out_x !== want.out_x) begin
                        $display("%0t: out_x mismatch: expected %0d, actual %0d",
                                 $time, want.out_x, o_result.out_x);
                        errors++;
                    end
                    if (o_result.out_y !== want.out_y) begin
                        $display("%0t: out_y mismatch: expected %0d, actual %0d",
                                 $time, want.out_y, o_result.out_y);
                        errors++;
                    end
                end
            end
            if (i_start && !o_busy) predict_item(i_item);
        end
    end

    task automatic queue_seed(int x, int y, logic [15:0] v);
        t_item it;
        it.action     = ACT_WRITE;
        it.cell_x     = x[7:0];
        it.cell_y     = y[7:0];
        it.seed_value = v;
        pending_items.push_back(it);
        seeded[y*MAP_SIZE + x] = 1'b1;
    endtask

    // A lookup is preceded by writes of every grid corner that any octave
    // could read and that has not been written yet, so the pair forms a
    // well-formed sequence. Returns how many items were queued.
    task automatic queue_lookup(int x, int y, output int added);
        t_item it;
        int p, x1, y1, x2, y2;
        int cx[4];
        int cy[4];
        added = 0;
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            p  = MAP_SIZE >> o;
            x1 = (x / p) * p;
            y1 = (y / p) * p;
            x2 = (x1 + p) % MAP_SIZE;
            y2 = (y1 + p) % MAP_SIZE;
            cx = '{x1, x2, x1, x2};
            cy = '{y1, y1, y2, y2};
            for (int k = 0; k < 4; k++) begin
                if (!seeded[cy[k]*MAP_SIZE + cx[k]]) begin
                    queue_seed(cx[k], cy[k], 16'($urandom_range(65535)));
                    added++;
                end
            end
        end
        it.action     = ACT_COMPUTE;
        it.cell_x     = x[7:0];
        it.cell_y     = y[7:0];
        it.seed_value = 16'($urandom_range(65535));
        pending_items.push_back(it);
        added++;
    endtask

    // Wait until the block has nothing left to do, then let a trailing seed
    // write settle before returning.
    task automatic drain();
        while (pending_items.size() != 0 || i_start || noise_due.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        bit hit;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            #1 hit = o_cfg_ready;
            @(posedge i_clk);
            if (hit) break;
            @(negedge i_clk);
        end
        if (idx == CFG_OCTAVES) pred_octaves = data[2:0];
        else pred_bias = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int n, added;
        int phase_oct[8];
        int phase_bias[8];
        int idle_set[3];

        errors       = 0;
        took         = 1'b0;
        idle_pct     = 0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_OCTAVES;
        i_cfg_data   = '0;
        pred_octaves = RST_OCTAVES;
        pred_bias    = RST_BIAS;
        foreach (seeded[i]) seeded[i] = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset settings: seed extremes, then lookups at
        // the map corners, where the grid wraps around the edges, and at two inner cells.
        queue_seed(0, 0, 16'hFFFF);
        queue_seed(255, 255, 16'h0000);
        queue_seed(128, 128, 16'hFFFF);
        queue_lookup(0, 0, added);
        queue_lookup(255, 255, added);
        queue_lookup(255, 0, added);
        queue_lookup(0, 255, added);
        queue_lookup(128, 128, added);
        queue_lookup(7, 9, added);
        drain();

        // Register settings per phase. An octave write of all ones lands as
        // seven, which behaves like zero octaves; a bias of zero saturates
        // the weights, one grows them fast and all ones shrinks them to zero.
        phase_oct  = '{0, 1, 6, 16'hFFFF, 3, 6, 2, 4};
        phase_bias = '{8192, 1, 65535, 0, 4096, 0, 12345, 5000};
        idle_set   = '{0, 57, 6};

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_OCTAVES, 16'(phase_oct[ph]));
            write_reg(CFG_BIAS, 16'(phase_bias[ph]));
            idle_pct = idle_set[ph % 3];
            n = 0;
            while (n < 92) begin
                if ($urandom_range(99) < 30) begin
                    // Stray seed write anywhere, sometimes at a value extreme.
                    case ($urandom_range(3))
                        0: queue_seed($urandom_range(255), $urandom_range(255), 16'h0000);
                        1: queue_seed($urandom_range(255), $urandom_range(255), 16'hFFFF);
                        default: queue_seed($urandom_range(255), $urandom_range(255),
                                            16'($urandom_range(65535)));
                    endcase
                    n++;
                end else begin
                    queue_lookup($urandom_range(255), $urandom_range(255), added);
                    n += added;
                end
            end
            // The sender holds off here until every owed result has come.
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (errors == 0 && noise_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
